// ----- rtl/occ_pkg.sv -----
package occ_pkg;

    typedef enum logic [2:0] {
        OP_BEGIN = 3'd0,
        OP_MOVE  = 3'd1,
        OP_LINE  = 3'd2,
        OP_QUAD  = 3'd3,
        OP_CUBIC = 3'd4,
        OP_END   = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        CMD_MOVE  = 2'd0,
        CMD_LINE  = 2'd1,
        CMD_CUBIC = 2'd2,
        CMD_CLOSE = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [15:0] q1x;
        logic [15:0] q1y;
        logic [15:0] q2x;
        logic [15:0] q2y;
        logic [15:0] tx;
        logic [15:0] ty;
    } pts_t;

    typedef struct packed {
        logic ld_a;
        logic ld_b;
    } tt_ld_t;

    // floor(n / 3) == (n * THIRD_RECIP) >> THIRD_SHIFT for every 17-bit n
    localparam logic [15:0] THIRD_RECIP = 16'd43691;
    localparam int          THIRD_SHIFT = 17;

endpackage

// ----- rtl/occ_two_thirds.sv -----
module occ_two_thirds (
    input  logic                 clk,
    input  occ_pkg::tt_ld_t      ld,
    input  logic signed [15:0]   base,
    input  logic signed [15:0]   ctrl,
    output logic signed [15:0]   res
);

    logic signed [16:0] diff;
    logic               neg;
    logic [15:0]        mag;
    logic [16:0]        num;
    logic [32:0]        prod;

    logic               neg_a_reg;
    logic [15:0]        base_a_reg;
    logic [16:0]        num_a_reg;
    logic               neg_b_reg;
    logic [15:0]        base_b_reg;
    logic [15:0]        quot_b_reg;

    always_comb
    begin
        diff = {ctrl[15], ctrl} - {base[15], base};
        neg  = diff[16];
        mag  = neg ? 16'(-diff) : diff[15:0];
        num  = {mag, 1'b1};
        prod = 33'(num_a_reg) * 33'(occ_pkg::THIRD_RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (ld.ld_a)
        begin
            neg_a_reg  <= neg;
            base_a_reg <= base;
            num_a_reg  <= num;
        end
        if (ld.ld_b)
        begin
            neg_b_reg  <= neg_a_reg;
            base_b_reg <= base_a_reg;
            quot_b_reg <= prod[occ_pkg::THIRD_SHIFT +: 16];
        end
    end

    assign res = neg_b_reg ? signed'(base_b_reg - quot_b_reg)
                           : signed'(base_b_reg + quot_b_reg);

endmodule

// ----- rtl/outline_path_to_cubic_commands_top.sv -----
// Outline events in, path commands out.
// Input channel: in_valid / in_stall with opcode and the control and target
// points; a transaction is taken when in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall with command, the two cubic controls,
// the end point and last_of_run, which marks the final command of an event.
// Begin, unused opcodes and an end with no open path give no command.
// A move on an open path gives a close and then the move.
// The first command of an event is registered through the input stage s1,
// then stages s2 and s3, then the output register.
// The pipeline takes one event per cycle while the receiver does not stall;
// a move that adds a close holds the last stage until both commands leave.
// The quadratic control rounding is one constant multiply per coordinate,
// registered between its own two stages.
// Reset clears the last end point to zero, the open-path flag and all
// valid flags; the pipeline then is empty and ready.
// When the receiver stalls, the output command holds; the stages behind it
// keep filling until the pipeline is full, then in_stall rises.
module outline_path_to_cubic_commands_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         opcode,
    input  logic signed [15:0] first_ctrl_x,
    input  logic signed [15:0] first_ctrl_y,
    input  logic signed [15:0] second_ctrl_x,
    input  logic signed [15:0] second_ctrl_y,
    input  logic signed [15:0] target_x,
    input  logic signed [15:0] target_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         command,
    output logic signed [15:0] out_c1_x,
    output logic signed [15:0] out_c1_y,
    output logic signed [15:0] out_c2_x,
    output logic signed [15:0] out_c2_y,
    output logic signed [15:0] out_end_x,
    output logic signed [15:0] out_end_y,
    output logic               last_of_run
);

    occ_pkg::op_t    in_op;
    logic            emits;
    logic            close_first;
    logic            upd_point;
    logic            open_next;
    occ_pkg::pts_t   in_pts;

    logic            out_ready;
    logic            s3_split;
    logic            s3_fire;
    logic            s3_free;
    logic            s2_free;
    logic            s1_free;
    logic            in_fire;
    occ_pkg::tt_ld_t tt_ld;

    logic            path_open_reg;
    logic [15:0]     prev_x_reg;
    logic [15:0]     prev_y_reg;
    logic            s1_valid_reg;
    logic            s2_valid_reg;
    logic            s3_valid_reg;
    logic            s3_close_done_reg;
    logic            out_valid_reg;
    logic            s1_valid_next;
    logic            s2_valid_next;
    logic            s3_valid_next;
    logic            s3_close_done_next;
    logic            out_valid_next;

    occ_pkg::op_t    s1_op_reg;
    occ_pkg::op_t    s2_op_reg;
    occ_pkg::op_t    s3_op_reg;
    logic            s1_close_reg;
    logic            s2_close_reg;
    logic            s3_close_reg;
    occ_pkg::pts_t   s1_pts_reg;
    occ_pkg::pts_t   s2_pts_reg;
    occ_pkg::pts_t   s3_pts_reg;
    logic [15:0]     s1_px_reg;
    logic [15:0]     s1_py_reg;

    logic signed [15:0] conv_c1x;
    logic signed [15:0] conv_c1y;
    logic signed [15:0] conv_c2x;
    logic signed [15:0] conv_c2y;

    occ_pkg::cmd_t   res_cmd;
    logic [15:0]     res_c1x;
    logic [15:0]     res_c1y;
    logic [15:0]     res_c2x;
    logic [15:0]     res_c2y;
    logic [15:0]     res_ex;
    logic [15:0]     res_ey;
    logic            res_last;

    occ_pkg::cmd_t   command_reg;
    logic [15:0]     c1x_reg;
    logic [15:0]     c1y_reg;
    logic [15:0]     c2x_reg;
    logic [15:0]     c2y_reg;
    logic [15:0]     ex_reg;
    logic [15:0]     ey_reg;
    logic            last_reg;

    // decode the incoming event against the current path state
    always_comb
    begin
        in_op       = occ_pkg::op_t'(opcode);
        emits       = 1'b0;
        close_first = 1'b0;
        upd_point   = 1'b0;
        open_next   = path_open_reg;
        unique case (in_op) inside
            occ_pkg::OP_BEGIN:
            begin
                open_next = 1'b0;
            end
            occ_pkg::OP_MOVE:
            begin
                emits       = 1'b1;
                close_first = path_open_reg;
                upd_point   = 1'b1;
                open_next   = 1'b1;
            end
            occ_pkg::OP_LINE:
            begin
                emits     = 1'b1;
                upd_point = 1'b1;
                open_next = 1'b1;
            end
            occ_pkg::OP_QUAD, occ_pkg::OP_CUBIC:
            begin
                emits     = 1'b1;
                upd_point = 1'b1;
            end
            occ_pkg::OP_END:
            begin
                emits     = path_open_reg;
                open_next = 1'b0;
            end
            default:
            begin
                emits = 1'b0;
            end
        endcase

        in_pts.q1x = first_ctrl_x;
        in_pts.q1y = first_ctrl_y;
        in_pts.q2x = second_ctrl_x;
        in_pts.q2y = second_ctrl_y;
        in_pts.tx  = target_x;
        in_pts.ty  = target_y;
    end

    // pipeline flow: a stage takes new data when it is empty or moving on
    always_comb
    begin
        out_ready = !out_valid_reg || !out_stall;
        s3_split  = s3_close_reg && !s3_close_done_reg;
        s3_fire   = s3_valid_reg && out_ready;
        s3_free   = !s3_valid_reg || (out_ready && !s3_split);
        s2_free   = !s2_valid_reg || s3_free;
        s1_free   = !s1_valid_reg || s2_free;
        in_fire   = in_valid && s1_free;

        tt_ld.ld_a = s2_free;
        tt_ld.ld_b = s3_free;

        s1_valid_next = s1_free ? (in_valid && emits) : s1_valid_reg;
        s2_valid_next = s2_free ? s1_valid_reg : s2_valid_reg;
        s3_valid_next = s3_free ? s2_valid_reg : s3_valid_reg;

        if (s3_free)
            s3_close_done_next = 1'b0;
        else if (s3_fire && s3_split)
            s3_close_done_next = 1'b1;
        else
            s3_close_done_next = s3_close_done_reg;

        if (s3_fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign in_stall = !s1_free;

    occ_two_thirds u_c1x (
        .clk  (clk),
        .ld   (tt_ld),
        .base (signed'(s1_px_reg)),
        .ctrl (signed'(s1_pts_reg.q1x)),
        .res  (conv_c1x)
    );

    occ_two_thirds u_c1y (
        .clk  (clk),
        .ld   (tt_ld),
        .base (signed'(s1_py_reg)),
        .ctrl (signed'(s1_pts_reg.q1y)),
        .res  (conv_c1y)
    );

    occ_two_thirds u_c2x (
        .clk  (clk),
        .ld   (tt_ld),
        .base (signed'(s1_pts_reg.tx)),
        .ctrl (signed'(s1_pts_reg.q1x)),
        .res  (conv_c2x)
    );

    occ_two_thirds u_c2y (
        .clk  (clk),
        .ld   (tt_ld),
        .base (signed'(s1_pts_reg.ty)),
        .ctrl (signed'(s1_pts_reg.q1y)),
        .res  (conv_c2y)
    );

    // form the command for the transaction leaving the last stage
    always_comb
    begin
        res_cmd  = occ_pkg::CMD_CLOSE;
        res_c1x  = 16'd0;
        res_c1y  = 16'd0;
        res_c2x  = 16'd0;
        res_c2y  = 16'd0;
        res_ex   = 16'd0;
        res_ey   = 16'd0;
        res_last = !s3_split;
        if (!s3_split)
        begin
            unique case (s3_op_reg)
                occ_pkg::OP_MOVE:
                begin
                    res_cmd = occ_pkg::CMD_MOVE;
                    res_ex  = s3_pts_reg.tx;
                    res_ey  = s3_pts_reg.ty;
                end
                occ_pkg::OP_LINE:
                begin
                    res_cmd = occ_pkg::CMD_LINE;
                    res_ex  = s3_pts_reg.tx;
                    res_ey  = s3_pts_reg.ty;
                end
                occ_pkg::OP_QUAD:
                begin
                    res_cmd = occ_pkg::CMD_CUBIC;
                    res_c1x = conv_c1x;
                    res_c1y = conv_c1y;
                    res_c2x = conv_c2x;
                    res_c2y = conv_c2y;
                    res_ex  = s3_pts_reg.tx;
                    res_ey  = s3_pts_reg.ty;
                end
                occ_pkg::OP_CUBIC:
                begin
                    res_cmd = occ_pkg::CMD_CUBIC;
                    res_c1x = s3_pts_reg.q1x;
                    res_c1y = s3_pts_reg.q1y;
                    res_c2x = s3_pts_reg.q2x;
                    res_c2y = s3_pts_reg.q2y;
                    res_ex  = s3_pts_reg.tx;
                    res_ey  = s3_pts_reg.ty;
                end
                default:
                begin
                    res_cmd = occ_pkg::CMD_CLOSE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            path_open_reg     <= 1'b0;
            prev_x_reg        <= 16'd0;
            prev_y_reg        <= 16'd0;
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            s3_valid_reg      <= 1'b0;
            s3_close_done_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                path_open_reg <= open_next;
                if (upd_point)
                begin
                    prev_x_reg <= target_x;
                    prev_y_reg <= target_y;
                end
            end
            s1_valid_reg      <= s1_valid_next;
            s2_valid_reg      <= s2_valid_next;
            s3_valid_reg      <= s3_valid_next;
            s3_close_done_reg <= s3_close_done_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free)
        begin
            s1_op_reg    <= in_op;
            s1_close_reg <= close_first;
            s1_pts_reg   <= in_pts;
            s1_px_reg    <= prev_x_reg;
            s1_py_reg    <= prev_y_reg;
        end
        if (s2_free)
        begin
            s2_op_reg    <= s1_op_reg;
            s2_close_reg <= s1_close_reg;
            s2_pts_reg   <= s1_pts_reg;
        end
        if (s3_free)
        begin
            s3_op_reg    <= s2_op_reg;
            s3_close_reg <= s2_close_reg;
            s3_pts_reg   <= s2_pts_reg;
        end
        if (s3_fire)
        begin
            command_reg <= res_cmd;
            c1x_reg     <= res_c1x;
            c1y_reg     <= res_c1y;
            c2x_reg     <= res_c2x;
            c2y_reg     <= res_c2y;
            ex_reg      <= res_ex;
            ey_reg      <= res_ey;
            last_reg    <= res_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign command     = command_reg;
    assign out_c1_x    = c1x_reg;
    assign out_c1_y    = c1y_reg;
    assign out_c2_x    = c2x_reg;
    assign out_c2_y    = c2y_reg;
    assign out_end_x   = ex_reg;
    assign out_end_y   = ey_reg;
    assign last_of_run = last_reg;

endmodule

// ----- tb/path_command_checker.sv -----
`timescale 1ns / 1ps

module path_command_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [2:0]         opcode,
    input  logic signed [15:0] first_ctrl_x,
    input  logic signed [15:0] first_ctrl_y,
    input  logic signed [15:0] second_ctrl_x,
    input  logic signed [15:0] second_ctrl_y,
    input  logic signed [15:0] target_x,
    input  logic signed [15:0] target_y,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [1:0]         command,
    input  logic signed [15:0] out_c1_x,
    input  logic signed [15:0] out_c1_y,
    input  logic signed [15:0] out_c2_x,
    input  logic signed [15:0] out_c2_y,
    input  logic signed [15:0] out_end_x,
    input  logic signed [15:0] out_end_y,
    input  logic               last_of_run,
    output int                 mismatches,
    output int                 outstanding
);

    typedef struct packed {
        occ_pkg::cmd_t cmd;
        logic [15:0]   c1x;
        logic [15:0]   c1y;
        logic [15:0]   c2x;
        logic [15:0]   c2y;
        logic [15:0]   ex;
        logic [15:0]   ey;
        logic          last;
    } path_cmd_t;

    path_cmd_t   pending_cmds[$];
    logic [15:0] pen_x;
    logic [15:0] pen_y;
    logic        contour_open;
    int          err_count = 0;

    function automatic path_cmd_t make_cmd(occ_pkg::cmd_t c,
                                           logic [15:0] c1x, logic [15:0] c1y,
                                           logic [15:0] c2x, logic [15:0] c2y,
                                           logic [15:0] ex, logic [15:0] ey,
                                           logic last);
        path_cmd_t r;
        r.cmd  = c;
        r.c1x  = c1x;
        r.c1y  = c1y;
        r.c2x  = c2x;
        r.c2y  = c2y;
        r.ex   = ex;
        r.ey   = ey;
        r.last = last;
        return r;
    endfunction

    task automatic queue_cmd(input path_cmd_t c);
        pending_cmds = {pending_cmds, c};
    endtask

    // 2d/3 rounded half away from zero
    function automatic int two_thirds_round(int d);
        int mag;
        int q;
        mag = (d < 0) ? -d : d;
        q   = (2 * mag + 1) / 3;
        return (d < 0) ? -q : q;
    endfunction

    function automatic logic [15:0] pull_towards(logic signed [15:0] from_pt,
                                                 logic signed [15:0] ctrl_pt);
        int from_i;
        int ctrl_i;
        int sum;
        from_i = from_pt;
        ctrl_i = ctrl_pt;
        sum    = from_i + two_thirds_round(ctrl_i - from_i);
        return sum[15:0];
    endfunction

    task automatic predict_commands(input logic [2:0] op,
                                    input logic signed [15:0] q1x,
                                    input logic signed [15:0] q1y,
                                    input logic signed [15:0] q2x,
                                    input logic signed [15:0] q2y,
                                    input logic signed [15:0] tx,
                                    input logic signed [15:0] ty);
        case (op)
            occ_pkg::OP_BEGIN:
            begin
                contour_open = 1'b0;
            end
            occ_pkg::OP_MOVE:
            begin
                if (contour_open)
                    queue_cmd(make_cmd(occ_pkg::CMD_CLOSE, 16'd0, 16'd0, 16'd0, 16'd0,
                                       16'd0, 16'd0, 1'b0));
                queue_cmd(make_cmd(occ_pkg::CMD_MOVE, 16'd0, 16'd0, 16'd0, 16'd0,
                                   tx, ty, 1'b1));
                contour_open = 1'b1;
            end
            occ_pkg::OP_LINE:
            begin
                queue_cmd(make_cmd(occ_pkg::CMD_LINE, 16'd0, 16'd0, 16'd0, 16'd0,
                                   tx, ty, 1'b1));
                contour_open = 1'b1;
            end
            occ_pkg::OP_QUAD:
            begin
                queue_cmd(make_cmd(occ_pkg::CMD_CUBIC,
                    pull_towards(pen_x, q1x), pull_towards(pen_y, q1y),
                    pull_towards(tx, q1x), pull_towards(ty, q1y),
                    tx, ty, 1'b1));
            end
            occ_pkg::OP_CUBIC:
            begin
                queue_cmd(make_cmd(occ_pkg::CMD_CUBIC, q1x, q1y, q2x, q2y, tx, ty, 1'b1));
            end
            occ_pkg::OP_END:
            begin
                if (contour_open)
                    queue_cmd(make_cmd(occ_pkg::CMD_CLOSE, 16'd0, 16'd0, 16'd0, 16'd0,
                                       16'd0, 16'd0, 1'b1));
                contour_open = 1'b0;
            end
            default:
            begin
            end
        endcase
        if (op == occ_pkg::OP_MOVE || op == occ_pkg::OP_LINE ||
            op == occ_pkg::OP_QUAD || op == occ_pkg::OP_CUBIC)
        begin
            pen_x = tx;
            pen_y = ty;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        path_cmd_t got;
        path_cmd_t want;
        if (!rst_n)
        begin
            pending_cmds.delete();
            pen_x        = 16'd0;
            pen_y        = 16'd0;
            contour_open = 1'b0;
            outstanding <= 0;
            mismatches  <= err_count;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = make_cmd(occ_pkg::cmd_t'(command), out_c1_x, out_c1_y,
                               out_c2_x, out_c2_y, out_end_x, out_end_y, last_of_run);
                if (pending_cmds.size() == 0)
                begin
                    if (err_count < 10)
                        $display("unexpected cmd %0d c1 (%0d,%0d) c2 (%0d,%0d) %s %0b",
                                 got.cmd, $signed(got.c1x), $signed(got.c1y),
                                 $signed(got.c2x), $signed(got.c2y),
                                 $sformatf("end (%0d,%0d) last", $signed(got.ex),
                                           $signed(got.ey)), got.last);
                    err_count++;
                end
                else
                begin
                    want = pending_cmds.pop_front();
                    if (got.cmd !== want.cmd || got.c1x !== want.c1x ||
                        got.c1y !== want.c1y || got.c2x !== want.c2x ||
                        got.c2y !== want.c2y || got.ex !== want.ex ||
                        got.ey !== want.ey || got.last !== want.last)
                    begin
                        if (err_count < 10)
                        begin
                            $display("mismatch expected cmd %0d c1 (%0d,%0d) c2 (%0d,%0d)",
                                     want.cmd, $signed(want.c1x), $signed(want.c1y),
                                     $signed(want.c2x), $signed(want.c2y));
                            $display("         expected end (%0d,%0d) last %0b",
                                     $signed(want.ex), $signed(want.ey), want.last);
                            $display("         actual   cmd %0d c1 (%0d,%0d) c2 (%0d,%0d)",
                                     got.cmd, $signed(got.c1x), $signed(got.c1y),
                                     $signed(got.c2x), $signed(got.c2y));
                            $display("         actual   end (%0d,%0d) last %0b",
                                     $signed(got.ex), $signed(got.ey), got.last);
                        end
                        err_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_commands(opcode, first_ctrl_x, first_ctrl_y, second_ctrl_x,
                                 second_ctrl_y, target_x, target_y);
            outstanding <= pending_cmds.size();
            mismatches  <= err_count;
        end
    end

endmodule

// ----- tb/outline_path_to_cubic_commands_top_tb.sv -----
`timescale 1ns / 1ps

module outline_path_to_cubic_commands_top_tb;

    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;
    localparam int         EVENT_TARGET = 950;
    localparam int         HOLD_OFF_CYCLES = 300;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [2:0]         opcode = 3'd0;
    logic signed [15:0] first_ctrl_x = 16'sd0;
    logic signed [15:0] first_ctrl_y = 16'sd0;
    logic signed [15:0] second_ctrl_x = 16'sd0;
    logic signed [15:0] second_ctrl_y = 16'sd0;
    logic signed [15:0] target_x = 16'sd0;
    logic signed [15:0] target_y = 16'sd0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         command;
    logic signed [15:0] out_c1_x;
    logic signed [15:0] out_c1_y;
    logic signed [15:0] out_c2_x;
    logic signed [15:0] out_c2_y;
    logic signed [15:0] out_end_x;
    logic signed [15:0] out_end_y;
    logic               last_of_run;

    int mismatches;
    int outstanding;
    int events_sent = 0;
    int send_burst = 0;

    always #1 clk = ~clk;

    outline_path_to_cubic_commands_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .first_ctrl_x  (first_ctrl_x),
        .first_ctrl_y  (first_ctrl_y),
        .second_ctrl_x (second_ctrl_x),
        .second_ctrl_y (second_ctrl_y),
        .target_x      (target_x),
        .target_y      (target_y),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .command       (command),
        .out_c1_x      (out_c1_x),
        .out_c1_y      (out_c1_y),
        .out_c2_x      (out_c2_x),
        .out_c2_y      (out_c2_y),
        .out_end_x     (out_end_x),
        .out_end_y     (out_end_y),
        .last_of_run   (last_of_run)
    );

    path_command_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .first_ctrl_x  (first_ctrl_x),
        .first_ctrl_y  (first_ctrl_y),
        .second_ctrl_x (second_ctrl_x),
        .second_ctrl_y (second_ctrl_y),
        .target_x      (target_x),
        .target_y      (target_y),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .command       (command),
        .out_c1_x      (out_c1_x),
        .out_c1_y      (out_c1_y),
        .out_c2_x      (out_c2_x),
        .out_c2_y      (out_c2_y),
        .out_end_x     (out_end_x),
        .out_end_y     (out_end_y),
        .last_of_run   (last_of_run),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    function automatic int draw_wait(inout int burst);
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            burst = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function automatic logic signed [15:0] rand_coord();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0, 1:    return r[15:0];
            2:
            begin
                case ($urandom_range(0, 4))
                    0:       return 16'sh8000;
                    1:       return 16'sh7FFF;
                    2:       return -16'sd1;
                    3:       return 16'sd1;
                    default: return 16'sd0;
                endcase
            end
            default: return $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
        endcase
    endfunction

    task automatic send_event(input logic [2:0] op,
                              input logic signed [15:0] q1x, input logic signed [15:0] q1y,
                              input logic signed [15:0] q2x, input logic signed [15:0] q2y,
                              input logic signed [15:0] tx, input logic signed [15:0] ty);
        int gap;
        gap = draw_wait(send_burst);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        opcode        <= op;
        first_ctrl_x  <= q1x;
        first_ctrl_y  <= q1y;
        second_ctrl_x <= q2x;
        second_ctrl_y <= q2y;
        target_x      <= tx;
        target_y      <= ty;
        in_valid      <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (op != OP_SPARE_A && op != OP_SPARE_B)
            events_sent++;
    endtask

    task automatic send_random(input logic [2:0] op);
        send_event(op, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), rand_coord());
    endtask

    task automatic send_glyph();
        int contours;
        int segs;
        logic [2:0] seg_op;
        if ($urandom_range(0, 7) != 0)
            send_random(occ_pkg::OP_BEGIN);
        contours = $urandom_range(1, 3);
        for (int c = 0; c < contours; c++)
        begin
            if ($urandom_range(0, 9) != 0)
                send_random(occ_pkg::OP_MOVE);
            segs = $urandom_range(1, 8);
            for (int s = 0; s < segs; s++)
            begin
                case ($urandom_range(0, 2))
                    0:       seg_op = occ_pkg::OP_LINE;
                    1:       seg_op = occ_pkg::OP_QUAD;
                    default: seg_op = occ_pkg::OP_CUBIC;
                endcase
                send_random(seg_op);
            end
        end
        if ($urandom_range(0, 7) != 0)
            send_random(occ_pkg::OP_END);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_random(occ_pkg::OP_END);
        send_random(occ_pkg::OP_BEGIN);
        send_event(occ_pkg::OP_QUAD, 16'sd1, -16'sd1, 16'sd7, 16'sd7, 16'sd2, -16'sd2);
        send_event(occ_pkg::OP_MOVE, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                   16'sh7FFF, 16'sh8000);
        send_event(occ_pkg::OP_LINE, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
                   16'sh8000, 16'sh7FFF);
        send_event(occ_pkg::OP_QUAD, 16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0,
                   16'sh8000, 16'sh7FFF);
        send_event(occ_pkg::OP_CUBIC, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
                   -16'sd1, 16'sd0);
        send_event(occ_pkg::OP_MOVE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                   16'sd0, 16'sd0);
        send_event(occ_pkg::OP_QUAD, 16'sd1, 16'sd2, 16'sd0, 16'sd0, -16'sd1, -16'sd2);
        send_event(occ_pkg::OP_QUAD, -16'sd1, -16'sd2, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_random(occ_pkg::OP_END);
        send_random(occ_pkg::OP_END);
        send_random(OP_SPARE_A);
        send_random(OP_SPARE_B);
        send_event(occ_pkg::OP_MOVE, 16'sd3, 16'sd3, 16'sd3, 16'sd3,
                   16'sh8000, 16'sh8000);
        send_event(occ_pkg::OP_QUAD, 16'sh7FFF, 16'sh7FFF, -16'sd1, -16'sd1,
                   16'sh8000, 16'sh8000);
        send_random(occ_pkg::OP_BEGIN);
        send_event(occ_pkg::OP_MOVE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd5, 16'sd5);
        send_random(occ_pkg::OP_CUBIC);
        send_random(occ_pkg::OP_END);
        send_event(occ_pkg::OP_LINE, 16'sd9, 16'sd9, 16'sd9, 16'sd9,
                   16'sd100, -16'sd100);
        send_random(occ_pkg::OP_MOVE);
        send_random(occ_pkg::OP_END);

        while (events_sent < EVENT_TARGET)
        begin
            if ($urandom_range(0, 7) == 0)
                send_random(3'($urandom_range(0, 7)));
            else
                send_glyph();
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        int recv_burst;
        int wait_cycles;
        int taken;
        recv_burst = 0;
        taken      = 0;
        @(posedge rst_n);
        forever
        begin
            if (taken == 150 || taken == 600)
                wait_cycles = HOLD_OFF_CYCLES;
            else
                wait_cycles = draw_wait(recv_burst);
            if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            taken++;
        end
    end

    initial
    begin
        #1000000;
        $display("FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/occ_pkg.sv
rtl/occ_two_thirds.sv
rtl/outline_path_to_cubic_commands_top.sv
tb/path_command_checker.sv
tb/outline_path_to_cubic_commands_top_tb.sv
